FILE: rtl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// Used by the parser front, the item queue, the unmasking back end and the top level.
// No dependencies.
package wsd_pkg;

  // Frame opcodes whose payload is delivered.
  localparam logic [3:0] OpText   = 4'd1;
  localparam logic [3:0] OpBinary = 4'd2;

  // Seven-bit length codes that announce an extended length field.
  localparam logic [6:0] LenExt16 = 7'd126;
  localparam logic [6:0] LenExt64 = 7'd127;

  // Width of the payload length counter.
  localparam int unsigned LenW = 64;

  // Depth of the queue between the parser and the back end.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  // One classified payload beat on its way to the back end.
  typedef struct packed {
    logic [7:0] data;       // byte as received
    logic [7:0] key;        // mask key byte that applies to it
    logic       is_binary;  // frame carries binary data
    logic       last;       // final payload byte of the frame
  } wsd_item_t;

endpackage

FILE: rtl/wsd_front.sv
// Parser front end: walks frame headers one byte per accepted cycle, classifies
// each payload byte, pairing it with its mask key byte. Depends on wsd_pkg.
module wsd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         byte_i,
  output logic               item_valid_o,
  output wsd_pkg::wsd_item_t item_o
);

  typedef enum logic [2:0] {
    PhFirst   = 3'd0,
    PhSecond  = 3'd1,
    PhExt16   = 3'd2,
    PhExt64   = 3'd3,
    PhKey     = 3'd4,
    PhPayload = 3'd5
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [2:0]                idx_q, idx_d;
  logic [3:0]                opcode_q, opcode_d;
  logic                      mask_q, mask_d;
  logic [wsd_pkg::LenW-1:0]  rem_q, rem_d;
  logic [31:0]               key_q, key_d;
  logic [1:0]                kp_q, kp_d;

  logic [2:0]                idx_inc;
  logic [2:0]                need;
  logic [wsd_pkg::LenW-1:0]  rem_shift;
  logic                      last;
  logic [7:0]                key_byte;
  logic [6:0]                len7;

  // Phase that follows a complete length field.
  function automatic phase_e after_length(input logic mask, input logic rem_zero);
    phase_e ph;
    if (mask) begin
      ph = PhKey;
    end else if (rem_zero) begin
      ph = PhFirst;
    end else begin
      ph = PhPayload;
    end
    return ph;
  endfunction

  assign idx_inc   = idx_q + 3'd1;
  assign need      = (phase_q == PhExt16) ? 3'd2 : 3'd0;
  assign rem_shift = {rem_q[wsd_pkg::LenW-9:0], byte_i};
  assign last      = (rem_q[wsd_pkg::LenW-1:1] == '0);
  assign len7      = byte_i[6:0];

  // Key byte for the current position, first key byte in the top bits.
  always_comb begin
    case (kp_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // The payload beat handed to the queue.
  always_comb begin
    item_o.data      = byte_i;
    item_o.key       = key_byte;
    item_o.is_binary = (opcode_q == wsd_pkg::OpBinary);
    item_o.last      = last;
  end

  // Header parsing and payload counting.
  always_comb begin
    phase_d      = phase_q;
    idx_d        = idx_q;
    opcode_d     = opcode_q;
    mask_d       = mask_q;
    rem_d        = rem_q;
    key_d        = key_q;
    kp_d         = kp_q;
    item_valid_o = 1'b0;
    if (accept_i) begin
      unique case (phase_q)
        PhSecond: begin
          mask_d = byte_i[7];
          key_d  = '0;
          kp_d   = '0;
          idx_d  = '0;
          rem_d  = '0;
          if (len7 == wsd_pkg::LenExt16) begin
            phase_d = PhExt16;
          end else if (len7 == wsd_pkg::LenExt64) begin
            phase_d = PhExt64;
          end else begin
            rem_d   = wsd_pkg::LenW'(len7);
            phase_d = after_length(byte_i[7], len7 == '0);
          end
        end
        PhExt16, PhExt64: begin
          rem_d = rem_shift;
          idx_d = idx_inc;
          if (idx_inc == need) begin
            idx_d   = '0;
            phase_d = after_length(mask_q, rem_shift == '0);
          end
        end
        PhKey: begin
          key_d = {key_q[23:0], byte_i};
          idx_d = idx_inc;
          if (idx_inc[2]) begin
            idx_d   = '0;
            kp_d    = '0;
            phase_d = (rem_q == '0) ? PhFirst : PhPayload;
          end
        end
        PhPayload: begin
          kp_d  = kp_q + 2'd1;
          rem_d = last ? '0 : rem_q - wsd_pkg::LenW'(1);
          if (last) begin
            phase_d = PhFirst;
          end
          item_valid_o = (opcode_q == wsd_pkg::OpText) || (opcode_q == wsd_pkg::OpBinary);
        end
        default: begin
          // First header byte, also taken for any unused phase code.
          opcode_d = byte_i[3:0];
          idx_d    = '0;
          phase_d  = PhSecond;
        end
      endcase
    end
  end

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhFirst;
      idx_q    <= '0;
      opcode_q <= '0;
      mask_q   <= 1'b0;
      rem_q    <= '0;
      key_q    <= '0;
      kp_q     <= '0;
    end else begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      rem_q    <= rem_d;
      key_q    <= key_d;
      kp_q     <= kp_d;
    end
  end

  // A frame in its payload always has bytes left to count.
  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPayload) |-> (rem_q != '0))
    else $error("payload phase with zero remaining length");

  // The key position advances by one on every accepted payload byte.
  a_key_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && phase_q == PhPayload) |=> (kp_q == $past(kp_q) + 2'd1))
    else $error("key position did not advance");

endmodule

FILE: rtl/wsd_queue.sv
// Short queue of classified payload beats between the parser and the back end.
// Depends on wsd_pkg for the beat type and the depth.
module wsd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  wsd_pkg::wsd_item_t item_i,
  input  logic               pop_i,
  output wsd_pkg::wsd_item_t item_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned Aw = wsd_pkg::QueueAw;

  wsd_pkg::wsd_item_t mem_q [wsd_pkg::QueueDepth];
  logic [Aw-1:0]      wr_ptr_q, wr_ptr_d;
  logic [Aw-1:0]      rd_ptr_q, rd_ptr_d;
  logic [Aw:0]        count_q, count_d;

  // Pointer advance with wrap at the queue depth.
  function automatic logic [Aw-1:0] ptr_next(input logic [Aw-1:0] p);
    logic [Aw-1:0] n;
    if (p == Aw'(wsd_pkg::QueueDepth - 1)) begin
      n = '0;
    end else begin
      n = p + Aw'(1);
    end
    return n;
  endfunction

  assign full_o  = (count_q == (Aw + 1)'(wsd_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (Aw + 1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (Aw + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (Aw + 1)'(wsd_pkg::QueueDepth))
    else $error("queue fill count beyond depth");

endmodule

FILE: rtl/wsd_back.sv
// Back end: takes classified beats from the queue, removes the mask and holds
// the result in an output register until it is taken. Depends on wsd_pkg.
module wsd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  wsd_pkg::wsd_item_t q_item_i,
  output logic               q_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [7:0]         payload_byte_o,
  output logic               is_binary_o,
  output logic               last_in_frame_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       bin_q;
  logic       last_q;

  // Refill the output register whenever it is free or being emptied.
  assign q_pop_o = !q_empty_i && (!valid_q || pop_i);

  always_comb begin
    valid_d = valid_q;
    if (q_pop_o) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Unmasked result beat.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      byte_q <= q_item_i.data ^ q_item_i.key;
      bin_q  <= q_item_i.is_binary;
      last_q <= q_item_i.last;
    end
  end

  assign empty_o         = !valid_q;
  assign payload_byte_o  = byte_q;
  assign is_binary_o     = bin_q;
  assign last_in_frame_o = last_q;

endmodule

FILE: rtl/websocket_frame_deframer.sv
// WebSocket receive deframer: one byte per clock in while not full, unmasked payload bytes
// out. An accepted payload byte passes through the queue into the output register.
// Throughput: one byte per cycle, set by the single-byte parser step; full rises only
// while the two-entry queue is full behind a stalled output register.
// Reset (asynchronous, active low) empties the queue and output and awaits a frame header.
// Instantiates wsd_front, wsd_queue and wsd_back; depends on wsd_pkg.
module websocket_frame_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] payload_byte_o,
  output logic       is_binary_o,
  output logic       last_in_frame_o
);

  logic               accept;
  logic               item_valid;
  wsd_pkg::wsd_item_t item;
  wsd_pkg::wsd_item_t q_item;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  wsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .byte_i       (in_byte_i),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  wsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (item_valid),
    .item_i  (item),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  wsd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .payload_byte_o  (payload_byte_o),
    .is_binary_o     (is_binary_o),
    .last_in_frame_o (last_in_frame_o)
  );

endmodule
